// ----- hdl/ffota_pkg.sv -----
package ffota_pkg;

  // Field widths of the request, result and configuration channels.
  localparam int KindW  = 1;
  localparam int SizeW  = 11;
  localparam int OwnerW = 10;
  localparam int StartW = 10;
  localparam int FreedW = 11;
  localparam int MsizeW = 11;
  // Wide enough to hold any owner id plus one for the OWNER_IDS range.
  localparam int LimW   = 17;

  localparam logic [MsizeW-1:0] MsizeReset = 11'd1024;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_FILL,
    ST_FREE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic alloc_step;
    logic fill_step;
    logic free_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic alloc_bad;
    logic free_bad;
    logic found;
    logic scan_end;
    logic fill_last;
    logic free_end;
  } status_t;

endpackage

// ----- hdl/ffota_ctrl.sv -----
module ffota_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ffota_pkg::status_t sts_i,
  output ffota_pkg::cmd_t   cmd_o
);
  import ffota_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = (in_kind_i == KindFree) ? ST_FREE : ST_ALLOC;
      end
      ST_ALLOC: begin
        if (sts_i.alloc_bad) state_d = ST_DONE;
        else if (sts_i.found) state_d = ST_FILL;
        else if (sts_i.scan_end) state_d = ST_DONE;
      end
      ST_FILL: begin
        if (sts_i.fill_last) state_d = ST_DONE;
      end
      ST_FREE: begin
        if (sts_i.free_bad || sts_i.free_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_ALLOC: cmd_o.alloc_step = !sts_i.alloc_bad;
      ST_FILL:  cmd_o.fill_step = 1'b1;
      ST_FREE:  cmd_o.free_step = !sts_i.free_bad;
      ST_DONE:  cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  // The result register is emptied by a transfer and refilled by out_load.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/ffota_dp.sv -----
module ffota_dp #(
  parameter int UNITS     = 1024,
  parameter int OWNER_IDS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffota_pkg::cmd_t               cmd_i,
  output ffota_pkg::status_t            sts_o,
  input  logic                          cfg_we_i,
  input  logic [ffota_pkg::MsizeW-1:0]  cfg_memory_size_i,
  input  logic [ffota_pkg::KindW-1:0]   in_kind_i,
  input  logic [ffota_pkg::SizeW-1:0]   in_request_size_i,
  input  logic [ffota_pkg::OwnerW-1:0]  in_owner_id_i,
  output logic                          out_success_o,
  output logic [ffota_pkg::StartW-1:0]  out_start_address_o,
  output logic [ffota_pkg::FreedW-1:0]  out_freed_units_o
);
  import ffota_pkg::*;

  localparam int AW    = $clog2(UNITS);
  localparam int CNT_W = $clog2(UNITS + 1);
  localparam int TAG_W = $clog2(OWNER_IDS + 1);
  localparam int SW    = (CNT_W > SizeW) ? CNT_W : SizeW;
  localparam int OSW   = (AW > StartW) ? AW : StartW;
  localparam int OFW   = (CNT_W > FreedW) ? CNT_W : FreedW;
  localparam logic [SW-1:0]   UnitsW  = SW'(UNITS);
  localparam logic [AW-1:0]   LastA   = AW'(UNITS - 1);
  localparam logic [LimW-1:0] OwnLim  = LimW'(OWNER_IDS);

  logic [TAG_W-1:0] mem [UNITS];
  logic [TAG_W-1:0] rdata_q;

  logic [MsizeW-1:0] msize_q;
  logic              kind_q;
  logic [SizeW-1:0]  size_q;
  logic [TAG_W-1:0]  tag_q;
  logic              own_ok_q;

  logic [CNT_W-1:0] addr_q, addr_d;
  logic             pvalid_q, pvalid_d;
  logic [AW-1:0]    paddr_q, paddr_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic [AW-1:0]    start_q, start_d;

  logic              out_success_q;
  logic [StartW-1:0] out_start_q;
  logic [FreedW-1:0] out_freed_q;

  logic [SW-1:0]   size_w, n_w, msz_w, addr_w, start_w;
  logic [LimW-1:0] owner_w;
  logic            rd_issue_a, rd_issue_f, hit_free, found_c, unit_free;
  logic            we;
  logic [AW-1:0]   wa;
  logic [TAG_W-1:0] wd;
  logic [OSW-1:0]  start_ext;
  logic [OFW-1:0]  freed_ext;

  assign size_w  = SW'(size_q);
  assign msz_w   = SW'(msize_q);
  assign n_w     = (msz_w < UnitsW) ? msz_w : UnitsW;
  assign addr_w  = SW'(addr_q);
  assign owner_w = LimW'(in_owner_id_i);

  assign unit_free  = (rdata_q == '0);
  assign found_c    = pvalid_q && unit_free && (SW'(run_q) + SW'(1) == size_w);
  assign start_w    = SW'(paddr_q) + SW'(1) - size_w;
  assign rd_issue_a = addr_w < n_w;
  assign rd_issue_f = addr_w < UnitsW;
  assign hit_free   = pvalid_q && (rdata_q == tag_q);

  assign sts_o.clr_last  = (addr_q[AW-1:0] == LastA);
  assign sts_o.alloc_bad = (size_q == '0) || (size_w > n_w) || !own_ok_q;
  assign sts_o.free_bad  = !own_ok_q;
  assign sts_o.found     = found_c;
  assign sts_o.scan_end  = !pvalid_q && !rd_issue_a;
  assign sts_o.fill_last = (SW'(cnt_q) + SW'(1) == size_w);
  assign sts_o.free_end  = !pvalid_q && !rd_issue_f;

  always_comb begin
    addr_d   = addr_q;
    pvalid_d = 1'b0;
    paddr_d  = addr_q[AW-1:0];
    run_d    = run_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    start_d  = start_q;
    we       = 1'b0;
    wa       = addr_q[AW-1:0];
    wd       = '0;
    if (cmd_i.clr_wr) begin
      we     = 1'b1;
      addr_d = sts_o.clr_last ? '0 : addr_q + CNT_W'(1);
    end
    if (cmd_i.load) begin
      addr_d  = '0;
      run_d   = '0;
      cnt_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.alloc_step) begin
      if (found_c) begin
        // Run is long enough: rewind to its first unit for the tag pass.
        found_d = 1'b1;
        start_d = start_w[AW-1:0];
        addr_d  = CNT_W'(start_w);
        cnt_d   = '0;
      end else begin
        pvalid_d = rd_issue_a;
        if (rd_issue_a) addr_d = addr_q + CNT_W'(1);
        if (pvalid_q) run_d = unit_free ? run_q + CNT_W'(1) : '0;
      end
    end
    if (cmd_i.fill_step) begin
      we     = 1'b1;
      wd     = tag_q;
      addr_d = addr_q + CNT_W'(1);
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (cmd_i.free_step) begin
      pvalid_d = rd_issue_f;
      if (rd_issue_f) addr_d = addr_q + CNT_W'(1);
      // The write trails the read by one unit, so it never hits the read address.
      if (hit_free) begin
        we    = 1'b1;
        wa    = paddr_q;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msize_q  <= MsizeReset;
      addr_q   <= '0;
      pvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) msize_q <= cfg_memory_size_i;
      addr_q   <= addr_d;
      pvalid_q <= pvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    run_q   <= run_d;
    cnt_q   <= cnt_d;
    found_q <= found_d;
    start_q <= start_d;
    if (cmd_i.load) begin
      kind_q   <= in_kind_i;
      size_q   <= in_request_size_i;
      own_ok_q <= owner_w < OwnLim;
      tag_q    <= TAG_W'(owner_w + LimW'(1));
    end
  end

  assign start_ext = OSW'(start_q);
  assign freed_ext = OFW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_success_q <= (kind_q == KindFree) || found_q;
      out_start_q   <= (kind_q == KindAlloc && found_q) ? start_ext[StartW-1:0] : '0;
      out_freed_q   <= (kind_q == KindFree) ? freed_ext[FreedW-1:0] : '0;
    end
  end

  assign out_success_o       = out_success_q;
  assign out_start_address_o = out_start_q;
  assign out_freed_units_o   = out_freed_q;

endmodule

// ----- hdl/first_fit_owner_tag_allocator_core.sv -----
// Allocate: accept, scan the units in use (plus the read pipe) for the first free run
// that fits, tag each unit of it, then load the result; a request that can never fit,
// or whose owner id is out of range, skips the scan. Free: accept, scan all UNITS units
// (plus the read pipe), load the result; an out-of-range owner id skips the scan.
// One item at a time: the input stalls until the result is loaded; a stalled result holds the load.
// After reset a clearing pass empties every unit of the tag memory; config is any time.
module first_fit_owner_tag_allocator_core #(
  parameter int UNITS     = 1024,
  parameter int OWNER_IDS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffota_pkg::MsizeW-1:0]  cfg_memory_size_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ffota_pkg::KindW-1:0]   in_kind_i,
  input  logic [ffota_pkg::SizeW-1:0]   in_request_size_i,
  input  logic [ffota_pkg::OwnerW-1:0]  in_owner_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_success_o,
  output logic [ffota_pkg::StartW-1:0]  out_start_address_o,
  output logic [ffota_pkg::FreedW-1:0]  out_freed_units_o
);
  import ffota_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  ffota_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i[0]),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffota_dp #(
    .UNITS     (UNITS),
    .OWNER_IDS (OWNER_IDS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_memory_size_i   (cfg_memory_size_i),
    .in_kind_i           (in_kind_i),
    .in_request_size_i   (in_request_size_i),
    .in_owner_id_i       (in_owner_id_i),
    .out_success_o       (out_success_o),
    .out_start_address_o (out_start_address_o),
    .out_freed_units_o   (out_freed_units_o)
  );

endmodule
